// ===== rtl/aat_pkg.sv =====
// Shared types, widths and constants for the affine box transform block.
// Used by aat_axis, aabb_affine_transform and aat_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aat_pkg;

  // Coordinate width of input and result fields (signed Q16.16)
  localparam int COORD_WIDTH = 32;

  // Fixed formats
  localparam int COEF_W     = 16;  // signed Q2.14 coefficient
  localparam int ROW_W      = 3 * COEF_W;
  localparam int OFF_W      = 32;  // signed Q16.16 offset
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

  // Product of one coefficient and one coordinate, and the sum of three of them
  localparam int PROD_W = COORD_WIDTH + COEF_W;
  localparam int OFFS_W = OFF_W + FRAC_SHIFT;
  localparam int SUM_W  = ((PROD_W > OFFS_W) ? PROD_W : OFFS_W) + 2;
  localparam int QUOT_W = SUM_W - FRAC_SHIFT;

  // Pipeline depth
  localparam int NSTAGE = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIN_ROW_X = 3'd0,
    CFG_LIN_ROW_Y = 3'd1,
    CFG_LIN_ROW_Z = 3'd2,
    CFG_OFFSET_X  = 3'd3,
    CFG_OFFSET_Y  = 3'd4,
    CFG_OFFSET_Z  = 3'd5
  } cfg_idx_t;

  localparam int CFG_DATA_W = ROW_W;

  // Reset values: identity rows, zero offsets
  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [2:0][COORD_WIDTH-1:0]   coord_vec_t;
  typedef logic [ROW_W-1:0]              row_t;
  typedef logic signed [OFF_W-1:0]       off_t;
  typedef logic signed [COEF_W-1:0]      coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic signed [QUOT_W-1:0]      quot_t;

  // Input box transaction
  typedef struct packed {
    coord_t in_min_x;
    coord_t in_min_y;
    coord_t in_min_z;
    coord_t in_max_x;
    coord_t in_max_y;
    coord_t in_max_z;
  } aat_in_t;

  // Result box transaction
  typedef struct packed {
    coord_t out_min_x;
    coord_t out_min_y;
    coord_t out_min_z;
    coord_t out_max_x;
    coord_t out_max_y;
    coord_t out_max_z;
  } aat_out_t;

  // Per-stage load enables sent to each axis lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } aat_ld_t;

endpackage

`default_nettype wire

// ===== rtl/aat_axis.sv =====
// One output axis of the box transform: multiply, bound, sum, round, saturate.
// Five register stages, loaded by enables from the top level. Uses aat_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aat_axis (
  input  wire                       clk,
  input  wire aat_pkg::row_t        row,
  input  wire aat_pkg::off_t        off,
  input  wire aat_pkg::coord_vec_t  lo,
  input  wire aat_pkg::coord_vec_t  hi,
  input  wire aat_pkg::aat_ld_t     ld,
  output aat_pkg::coord_t           min_o,
  output aat_pkg::coord_t           max_o
);
  import aat_pkg::*;

  localparam coord_t SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  // Round the Q.30 sum back to Q16.16 and clamp to the coordinate range
  function automatic coord_t round_sat(input sum_t total);
    quot_t q;
    q = quot_t'(total >>> FRAC_SHIFT);
    if ((q[QUOT_W-1:COORD_WIDTH-1] == '0) || (q[QUOT_W-1:COORD_WIDTH-1] == '1)) begin
      return q[COORD_WIDTH-1:0];
    end else if (q[QUOT_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  prod_t prod_lo_nxt [3];
  prod_t prod_hi_nxt [3];
  prod_t prod_lo_r   [3];
  prod_t prod_hi_r   [3];
  prod_t tmin_nxt    [3];
  prod_t tmax_nxt    [3];
  prod_t tmin_r      [3];
  prod_t tmax_r      [3];
  sum_t  min_a_nxt, min_b_nxt, max_a_nxt, max_b_nxt;
  sum_t  min_a_r, min_b_r, max_a_r, max_b_r;
  sum_t  min_sum_nxt, max_sum_nxt, min_sum_r, max_sum_r;
  coord_t min_nxt, max_nxt, min_r, max_r;

  // Stage 1: coefficient times each corner coordinate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_lo_nxt[k] = prod_t'(coef_t'(row[COEF_W*k +: COEF_W])) * prod_t'(coord_t'(lo[k]));
      prod_hi_nxt[k] = prod_t'(coef_t'(row[COEF_W*k +: COEF_W])) * prod_t'(coord_t'(hi[k]));
    end
  end

  // Stage 2: smaller and larger term of each input axis
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (prod_lo_r[k] < prod_hi_r[k]) begin
        tmin_nxt[k] = prod_lo_r[k];
        tmax_nxt[k] = prod_hi_r[k];
      end else begin
        tmin_nxt[k] = prod_hi_r[k];
        tmax_nxt[k] = prod_lo_r[k];
      end
    end
  end

  // Stage 3: two partial sums, offset and rounding half folded into one
  always_comb begin
    min_a_nxt = sum_t'(tmin_r[0]) + sum_t'(tmin_r[1]);
    max_a_nxt = sum_t'(tmax_r[0]) + sum_t'(tmax_r[1]);
    min_b_nxt = sum_t'(tmin_r[2]) + (sum_t'(off) <<< FRAC_SHIFT) + sum_t'(ROUND_HALF);
    max_b_nxt = sum_t'(tmax_r[2]) + (sum_t'(off) <<< FRAC_SHIFT) + sum_t'(ROUND_HALF);
  end

  // Stage 4: full sum; stage 5: round and saturate
  assign min_sum_nxt = min_a_r + min_b_r;
  assign max_sum_nxt = max_a_r + max_b_r;
  assign min_nxt     = round_sat(min_sum_r);
  assign max_nxt     = round_sat(max_sum_r);

  // Advance each stage when the top level lets it load
  always_ff @(posedge clk) begin
    if (ld.s1) begin
      prod_lo_r <= prod_lo_nxt;
      prod_hi_r <= prod_hi_nxt;
    end
    if (ld.s2) begin
      tmin_r <= tmin_nxt;
      tmax_r <= tmax_nxt;
    end
    if (ld.s3) begin
      min_a_r <= min_a_nxt;
      min_b_r <= min_b_nxt;
      max_a_r <= max_a_nxt;
      max_b_r <= max_b_nxt;
    end
    if (ld.s4) begin
      min_sum_r <= min_sum_nxt;
      max_sum_r <= max_sum_nxt;
    end
    if (ld.s5) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign min_o = min_r;
  assign max_o = max_r;

endmodule

`default_nettype wire

// ===== rtl/aabb_affine_transform.sv =====
// Top level of the axis-aligned box affine transform block.
// Holds configuration registers and pipeline valid bits; uses aat_pkg, aat_axis.
//
// Each box transaction passes through a five-stage pipeline (multiply, per-axis
// min/max, partial sums, full sum, round and saturate); one box is accepted
// every cycle while in_stall is low. Eighteen 16x32 multipliers, six per output
// axis, work in parallel in the first stage. A stall at the output holds the
// final stage while bubbles in earlier stages still fill; in_stall rises only
// when every stage is full. Configuration registers take effect on the next
// accepted box and must be written only while the pipeline is empty;
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module aabb_affine_transform (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire aat_pkg::aat_in_t                 in_data,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output aat_pkg::aat_out_t                     out_data,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire [aat_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire [aat_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import aat_pkg::*;

  row_t lin_row_x_r, lin_row_y_r, lin_row_z_r;
  off_t offset_x_r, offset_y_r, offset_z_r;

  logic [NSTAGE-1:0] v_r, v_nxt, rdy;
  aat_ld_t           ld;
  coord_vec_t        lo, hi;

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_row_x_r <= ROW_X_RST;
      lin_row_y_r <= ROW_Y_RST;
      lin_row_z_r <= ROW_Z_RST;
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      offset_z_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIN_ROW_X: lin_row_x_r <= cfg_data[ROW_W-1:0];
        CFG_LIN_ROW_Y: lin_row_y_r <= cfg_data[ROW_W-1:0];
        CFG_LIN_ROW_Z: lin_row_z_r <= cfg_data[ROW_W-1:0];
        CFG_OFFSET_X:  offset_x_r  <= cfg_data[OFF_W-1:0];
        CFG_OFFSET_Y:  offset_y_r  <= cfg_data[OFF_W-1:0];
        CFG_OFFSET_Z:  offset_z_r  <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage can load when empty or when the stage after it moves on
  always_comb begin
    rdy[NSTAGE-1] = !v_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  // Advance valid bits along with the data
  always_comb begin
    v_nxt = v_r;
    if (rdy[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTAGE; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign ld = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NSTAGE-1];

  assign lo = {in_data.in_min_z, in_data.in_min_y, in_data.in_min_x};
  assign hi = {in_data.in_max_z, in_data.in_max_y, in_data.in_max_x};

  // One lane per output axis
  aat_axis u_axis_x (
    .clk   (clk),
    .row   (lin_row_x_r),
    .off   (offset_x_r),
    .lo    (lo),
    .hi    (hi),
    .ld    (ld),
    .min_o (out_data.out_min_x),
    .max_o (out_data.out_max_x)
  );

  aat_axis u_axis_y (
    .clk   (clk),
    .row   (lin_row_y_r),
    .off   (offset_y_r),
    .lo    (lo),
    .hi    (hi),
    .ld    (ld),
    .min_o (out_data.out_min_y),
    .max_o (out_data.out_max_y)
  );

  aat_axis u_axis_z (
    .clk   (clk),
    .row   (lin_row_z_r),
    .off   (offset_z_r),
    .lo    (lo),
    .hi    (hi),
    .ld    (ld),
    .min_o (out_data.out_min_z),
    .max_o (out_data.out_max_z)
  );

endmodule

`default_nettype wire

// ===== rtl/aat_checker.sv =====
// Port-level checks for aabb_affine_transform, bound to every instance of it.
// Uses aat_pkg for the result transaction type.
`timescale 1ns / 1ps
`default_nettype none

module aat_checker (
  input wire                    clk,
  input wire                    rst_n,
  input wire                    in_stall,
  input wire                    out_valid,
  input wire                    out_stall,
  input wire aat_pkg::aat_out_t out_data
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Input stalls only when a result waits on a stalled output
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // A stalled result transaction stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (.*);

`default_nettype wire
